// ===== hw/rtl/stm_pkg.sv =====
// Shared types and constants for the subscription table.
// Depends on nothing; the interfaces, stm_engine and the top import it.
package stm_pkg;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int CODE_W   = 16;
    localparam int LIFE_W   = 24;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int MS_W     = 10;

    localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;

    localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [CODE_W-1:0] service;
        logic [CODE_W-1:0] inst;
        logic [CODE_W-1:0] group;
    } key_t;

    typedef struct packed {
        key_t              key;
        logic [LIFE_W-1:0] lifetime;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   expiry;
    } done_t;

endpackage

// ===== hw/rtl/stm_req_if.sv =====
// Request channel of the subscription table: valid/ready plus key, lifetime and time.
// Depends on stm_pkg.
interface stm_req_if;
    import stm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] endpoint_addr;
    logic [PORT_W-1:0] endpoint_port;
    logic [CODE_W-1:0] service_code;
    logic [CODE_W-1:0] instance_code;
    logic [CODE_W-1:0] group_code;
    logic [LIFE_W-1:0] lifetime_s;
    logic [TIME_W-1:0] now_ms;

    modport source (
        output valid, endpoint_addr, endpoint_port, service_code, instance_code,
               group_code, lifetime_s, now_ms,
        input  ready
    );

    modport sink (
        input  valid, endpoint_addr, endpoint_port, service_code, instance_code,
               group_code, lifetime_s, now_ms,
        output ready
    );
endinterface

// ===== hw/rtl/stm_rsp_if.sv =====
// Result channel of the subscription table: valid/ready plus status, slot and expiry.
// Depends on stm_pkg.
interface stm_rsp_if;
    import stm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   expiry_ms;

    modport source (
        output valid, status, slot, expiry_ms,
        input  ready
    );

    modport sink (
        input  valid, status, slot, expiry_ms,
        output ready
    );
endinterface

// ===== hw/rtl/stm_mem.sv =====
// Single-port-write, single-port-read synchronous RAM holding the table entries.
// Read data is registered. No dependencies.
module stm_mem #(
    parameter int WIDTH = 152,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/stm_engine.sv =====
// Request engine: captures a request, scans the table memory one entry a cycle, then refreshes,
// adds or removes, or reports full or not found, and presents the result. Depends on stm_pkg, stm_req_if.
module stm_engine #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    stm_req_if.sink                 req,
    output logic                    mem_wr_en,
    output logic [IDX_W-1:0]        mem_wr_addr,
    output logic [stm_pkg::ENTRY_W-1:0] mem_wr_data,
    output logic                    mem_rd_en,
    output logic [IDX_W-1:0]        mem_rd_addr,
    input  logic [stm_pkg::ENTRY_W-1:0] mem_rd_data,
    output stm_pkg::done_t          done,
    input  logic                    done_ready
);
    import stm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t state_reg, state_next;

    logic [TABLE_ENTRIES-1:0] active_reg, active_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;

    key_t              key_reg;
    logic [LIFE_W-1:0] life_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] prod_reg;
    logic [TIME_W-1:0] expiry_reg;

    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;

    logic                      accept;
    entry_t                    rd_entry;
    logic                      slot_active;
    logic                      match_now;
    logic                      free_now;
    logic [LIFE_W+MS_W-1:0]    prod_full;
    logic [SLOT_W+IDX_W-1:0]   slot_wide;

    assign accept   = req.valid && req.ready;
    assign rd_entry = entry_t'(mem_rd_data);

    assign slot_active = active_reg[rd_idx_reg];
    assign match_now   = rd_valid_reg && slot_active && (rd_entry.key == key_reg);
    assign free_now    = rd_valid_reg && !slot_active;

    assign prod_full = {{MS_W{1'b0}}, life_reg} * {{LIFE_W{1'b0}}, MS_PER_S};

    // Slot reports the low bits of the index only.
    assign slot_wide = {{SLOT_W{1'b0}}, res_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.addr    <= req.endpoint_addr;
            key_reg.port    <= req.endpoint_port;
            key_reg.service <= req.service_code;
            key_reg.inst    <= req.instance_code;
            key_reg.group   <= req.group_code;
            life_reg        <= req.lifetime_s;
            now_reg         <= req.now_ms;
        end
        // Product, then expiry, are registered in turn after capture, ready before the update step.
        prod_reg     <= prod_full[TIME_W-1:0];
        expiry_reg   <= now_reg + prod_reg;
        rd_idx_reg   <= scan_idx_reg;
        scan_idx_reg <= scan_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        res_idx_reg  <= res_idx_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        rd_valid_next = 1'b0;
        scan_idx_next = scan_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        status_next   = status_reg;
        res_idx_next  = res_idx_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = hit_idx_reg;
        mem_wr_data = {key_reg, life_reg, expiry_reg};

        req.ready = (state_reg == ST_IDLE);

        // Lowest match and lowest free slot win.
        if (match_now && !hit_reg)
        begin
            hit_next     = 1'b1;
            hit_idx_next = rd_idx_reg;
        end
        if (free_now && !free_reg)
        begin
            free_next     = 1'b1;
            free_idx_next = rd_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_rd_en     = 1'b1;
                rd_valid_next = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (life_reg != '0)
                begin
                    if (hit_reg)
                    begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = hit_idx_reg;
                        status_next  = STATUS_REFRESHED;
                        res_idx_next = hit_idx_reg;
                    end
                    else if (free_reg)
                    begin
                        mem_wr_en                 = 1'b1;
                        mem_wr_addr               = free_idx_reg;
                        active_next[free_idx_reg] = 1'b1;
                        status_next               = STATUS_ADDED;
                        res_idx_next              = free_idx_reg;
                    end
                    else
                    begin
                        status_next  = STATUS_FULL;
                        res_idx_next = '0;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        // Drop the entry; the stored fields stay but no longer match.
                        active_next[hit_idx_reg] = 1'b0;
                        status_next              = STATUS_REMOVED;
                        res_idx_next             = hit_idx_reg;
                    end
                    else
                    begin
                        status_next  = STATUS_NOT_FOUND;
                        res_idx_next = '0;
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done.valid  = (state_reg == ST_RESULT);
    assign done.status = status_reg;
    assign done.slot   = slot_wide[SLOT_W-1:0];
    assign done.expiry = expiry_reg;

endmodule

// ===== hw/rtl/subscription_table_match_insert_remove_top.sv =====
// Requests are taken only while the engine is idle, so a new request waits until the
// previous result has moved into the output register. The scan reads one table entry per
// cycle from the entry memory.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, asynchronous) marks every entry inactive; the entry memory is not cleared.
// Depends on stm_pkg, stm_req_if, stm_rsp_if, stm_mem, stm_engine.
module subscription_table_match_insert_remove_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    stm_req_if.sink   req,
    stm_rsp_if.source rsp
);
    import stm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    done_t eng_done;
    logic  done_ready;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TIME_W-1:0]   out_expiry_reg;

    stm_mem #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    stm_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .done        (eng_done),
        .done_ready  (done_ready)
    );

    // Take a new result when the register is empty or being emptied.
    assign done_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= eng_done.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && eng_done.valid)
        begin
            out_status_reg <= eng_done.status;
            out_slot_reg   <= eng_done.slot;
            out_expiry_reg <= eng_done.expiry;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.slot      = out_slot_reg;
    assign rsp.expiry_ms = out_expiry_reg;

`ifndef ASSERT_OFF
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !eng_done.valid)
        else $error("request taken while a result is pending in the engine");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        eng_done.valid && !done_ready |=> eng_done.valid && $stable(eng_done.status)
            && $stable(eng_done.slot))
        else $error("engine result lost while the output register was full");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == STATUS_FULL || rsp.status == STATUS_NOT_FOUND)
            |-> rsp.slot == '0)
        else $error("nonzero slot reported with full or not found");
`endif

endmodule
